// ===== design/pdd_pkg.sv =====
// Shared types and constants for the probe request SSID dedup block.
// No dependencies.
package pdd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SSID_MAX    = 32;
    localparam int ECW         = $clog2(TABLE_DEPTH + 1);
    localparam int WCW         = $clog2(TABLE_DEPTH + 3);

    localparam logic [7:0] TYPE_MASK   = 8'hf0;
    localparam logic [7:0] TYPE_PROBE  = 8'h40;
    localparam logic [7:0] ID_SSID     = 8'h00;
    localparam logic [7:0] CHAR_LOW    = 8'h20;
    localparam logic [7:0] CHAR_DEL    = 8'h7f;
    localparam logic [11:0] HDR_LAST   = 12'd23;
    localparam logic [11:0] ADDR_FIRST = 12'd10;
    localparam logic [11:0] ADDR_LAST  = 12'd15;
    localparam logic [11:0] POS_MAX    = 12'd4095;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [47:0]                 addr;
        logic [5:0]                  len;
        logic [SSID_MAX-1:0][7:0]    chars;
    } t_key;

endpackage

// ===== design/probe_request_ssid_dedup.sv =====
// Probe request SSID extractor with dedup table: top level.
// Depends on pdd_pkg, pdd_parse and pdd_cell.
//
// Frame bytes come in one transfer per byte, one per cycle while the block
// takes input. At the final byte of a management frame of at least 16
// bytes the block stops taking input and searches its table: a row of
// TABLE_DEPTH cells, each holding one (address, SSID) pair, compares
// against the frame's key at once and ripples a match flag down the row,
// one cell per cycle. Then it offers one summary transfer and, for a new
// pair, one transfer per kept SSID character, each as fast as the receiver
// takes it. A new pair is written into the next free cell; when all cells
// are used the summary flags table_full and nothing is stored. A clear
// operation empties the table and leaves the frame in progress as it is.
module probe_request_ssid_dedup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic        i_frame_is_mgmt,
    input  logic signed [7:0] i_signal_strength,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic        o_is_new,
    output logic        o_table_full,
    output logic [47:0] o_source_address,
    output logic signed [7:0] o_frame_strength,
    output logic        o_is_probe,
    output logic [5:0]  o_ssid_length,
    output logic [7:0]  o_ssid_char,
    output logic        o_last
);
    import pdd_pkg::*;

    typedef enum logic [3:0] {
        S_IN   = 4'b0001,
        S_SRCH = 4'b0010,
        S_SUM  = 4'b0100,
        S_CHR  = 4'b1000
    } t_state;

    t_state          r_state;
    logic [ECW-1:0]  r_cnt;
    logic [WCW-1:0]  r_wait;
    logic [5:0]      r_k;
    logic            r_fresh, r_full;

    t_key            key;
    logic [7:0]      strength;
    logic            probe, long_frame;
    logic            in_xfer, out_xfer, byte_xfer, restart, done_srch;
    logic            fresh, ins;
    logic [TABLE_DEPTH:0] acc;
    logic [7:0]      chr;

    assign o_stall   = (r_state != S_IN);
    assign in_xfer   = i_valid && !o_stall;
    assign byte_xfer = in_xfer && (i_operation == OP_BYTE);
    assign out_xfer  = o_valid && !i_stall;
    assign done_srch = (r_state == S_SRCH) && (r_wait == WCW'(TABLE_DEPTH + 1));
    assign fresh     = !acc[TABLE_DEPTH];
    assign ins       = done_srch && fresh && (r_cnt != ECW'(TABLE_DEPTH));

    // Restart the parser on a dropped frame or after the last result.
    always_comb begin
        restart = 1'b0;
        if (byte_xfer && i_frame_last && !(i_frame_is_mgmt && long_frame)) restart = 1'b1;
        if (out_xfer && o_last) restart = 1'b1;
    end

    pdd_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (byte_xfer),
        .i_restart  (restart),
        .i_byte     (i_frame_byte),
        .i_strength (i_signal_strength),
        .o_key      (key),
        .o_strength (strength),
        .o_probe    (probe),
        .o_long     (long_frame)
    );

    // Match flag enters the row clear and picks up hits cell by cell.
    assign acc[0] = 1'b0;
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pdd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_key    (key),
            .i_wr     (ins && r_cnt == ECW'(g)),
            .i_active (ECW'(g) < r_cnt),
            .i_acc    (acc[g]),
            .o_acc    (acc[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt   <= '0;
            r_wait  <= '0;
            r_k     <= '0;
            r_fresh <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            case (r_state)
                S_IN: begin
                    if (in_xfer && i_operation == OP_CLEAR) r_cnt <= '0;
                    if (byte_xfer && i_frame_last && i_frame_is_mgmt && long_frame) begin
                        r_state <= S_SRCH;
                        r_wait  <= '0;
                    end
                end
                S_SRCH: begin
                    r_wait <= r_wait + WCW'(1);
                    if (done_srch) begin
                        r_fresh <= fresh;
                        r_full  <= fresh && !ins;
                        if (ins) r_cnt <= r_cnt + ECW'(1);
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (out_xfer) begin
                        r_k     <= '0;
                        r_state <= o_last ? S_IN : S_CHR;
                    end
                end
                S_CHR: begin
                    if (out_xfer) begin
                        r_k <= r_k + 6'd1;
                        if (o_last) r_state <= S_IN;
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    // Select the character at the output index.
    always_comb begin
        chr = '0;
        for (int j = 0; j < SSID_MAX; j++) begin
            if (r_k == 6'(j)) chr = key.chars[j];
        end
    end

    assign o_valid          = (r_state == S_SUM) || (r_state == S_CHR);
    assign o_kind           = (r_state == S_CHR);
    assign o_is_new         = r_fresh;
    assign o_table_full     = r_full;
    assign o_source_address = key.addr;
    assign o_frame_strength = strength;
    assign o_is_probe       = probe;
    assign o_ssid_length    = key.len;
    assign o_ssid_char      = (r_state == S_CHR) ? chr : 8'd0;
    assign o_last           = (r_state == S_SUM) ? (!r_fresh || key.len == 6'd0)
                                                 : (r_k + 6'd1 == key.len);
endmodule

// ===== design/pdd_parse.sv =====
// Frame byte parser: header capture and information element walk.
// Depends on pdd_pkg.
module pdd_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_restart,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_strength,
    output pdd_pkg::t_key o_key,
    output logic [7:0]    o_strength,
    output logic          o_probe,
    output logic          o_long
);
    import pdd_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_ID       = 7'b0000010,
        PH_LEN_OTH  = 7'b0000100,
        PH_LEN_SSID = 7'b0001000,
        PH_SKIP     = 7'b0010000,
        PH_SSID     = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    logic [11:0] r_pos;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_rem, n_rem;
    logic [47:0] r_addr;
    logic [7:0]  r_str;
    logic        r_probe;
    logic [5:0]  r_cnt, n_cnt;
    logic [SSID_MAX-1:0][7:0] r_chars;

    logic        first, probe_now, keep, rem_z;
    t_phase      ph;
    logic [5:0]  cnt;
    logic [7:0]  rem_dec;

    always_comb begin
        first     = (r_pos == 12'd0);
        probe_now = ((i_byte & TYPE_MASK) == TYPE_PROBE);
        ph        = first ? (probe_now ? PH_HEADER : PH_DONE) : r_phase;
        cnt       = first ? 6'd0 : r_cnt;
        rem_dec   = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;
        rem_z     = (rem_dec == 8'd0);
        n_phase   = ph;
        n_rem     = r_rem;
        n_cnt     = cnt;
        keep      = 1'b0;
        case (ph)
            PH_HEADER: begin
                if (r_pos == HDR_LAST) n_phase = PH_ID;
            end
            PH_ID: begin
                n_phase = (i_byte == ID_SSID) ? PH_LEN_SSID : PH_LEN_OTH;
            end
            PH_LEN_OTH: begin
                n_rem   = i_byte;
                n_phase = (i_byte == 8'd0) ? PH_ID : PH_SKIP;
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_z) n_phase = PH_ID;
            end
            PH_LEN_SSID: begin
                n_rem   = (i_byte > 8'(SSID_MAX)) ? 8'(SSID_MAX) : i_byte;
                n_phase = (i_byte == 8'd0) ? PH_DONE : PH_SSID;
            end
            PH_SSID: begin
                if (i_byte == 8'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    keep  = (i_byte >= CHAR_LOW) && (i_byte != CHAR_DEL)
                            && (cnt < 6'(SSID_MAX));
                    if (keep) n_cnt = cnt + 6'd1;
                    n_rem = rem_dec;
                    if (rem_z) n_phase = PH_DONE;
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_rem   <= '0;
            r_addr  <= '0;
            r_str   <= '0;
            r_probe <= 1'b0;
            r_cnt   <= '0;
        end else if (i_en) begin
            if (first) begin
                r_str   <= i_strength;
                r_probe <= probe_now;
            end
            if (r_pos >= ADDR_FIRST && r_pos <= ADDR_LAST)
                r_addr <= {r_addr[39:0], i_byte};
            else if (first)
                r_addr <= '0;
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            if (r_pos != POS_MAX) r_pos <= r_pos + 12'd1;
        end
    end

    // Character store, written at the running count.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SSID_MAX; j++) begin
            if (i_en && keep && cnt == 6'(j)) r_chars[j] <= i_byte;
        end
    end

    assign o_key.addr  = r_addr;
    assign o_key.len   = r_cnt;
    assign o_key.chars = r_chars;
    assign o_strength  = r_str;
    assign o_probe     = r_probe;
    assign o_long      = (r_pos >= ADDR_LAST);
endmodule

// ===== design/pdd_cell.sv =====
// One dedup table entry: stores a pair, compares it with the key and
// passes the running match flag to the next cell. Depends on pdd_pkg.
module pdd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pdd_pkg::t_key i_key,
    input  logic          i_wr,
    input  logic          i_active,
    input  logic          i_acc,
    output logic          o_acc
);
    import pdd_pkg::*;

    t_key r_ent;
    logic r_hit, r_acc;
    logic match;

    always_comb begin
        match = (r_ent.addr == i_key.addr) && (r_ent.len == i_key.len);
        for (int j = 0; j < SSID_MAX; j++) begin
            if (6'(j) < i_key.len && r_ent.chars[j] != i_key.chars[j]) match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_ent <= i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            r_hit <= match && i_active;
            r_acc <= i_acc || r_hit;
        end
    end

    assign o_acc = r_acc;
endmodule
